>>> rtl/dda_lr_pkg.sv
`default_nettype none

package dda_lr_pkg;

	localparam int COORD_BITS  = 10;
	localparam int FRAC_BITS   = 16;
	localparam int COLOUR_BITS = 4;

	// Accumulators: sign, COORD_BITS integer bits, FRAC_BITS fraction bits.
	localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 1;
	// Increments: sign, one integer bit, FRAC_BITS fraction bits.
	localparam int INC_BITS = FRAC_BITS + 2;
	// Dividend of the slope division.
	localparam int NUM_BITS = COORD_BITS + FRAC_BITS;
	localparam int CNT_BITS = $clog2(NUM_BITS);

	localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOUR_BITS;
	localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef struct packed {
		logic load;
		logic div_step;
		logic div_last;
		logic emit;
	} dda_lr_cmd_t;

	typedef struct packed {
		logic steps_zero;
		logic last;
	} dda_lr_sts_t;

endpackage

`default_nettype wire

>>> rtl/dda_lr_datapath.sv
`default_nettype none

module dda_lr_datapath (
	input  wire logic                                  clk,
	input  wire logic [dda_lr_pkg::S_TDATA_BITS-1:0]   s_tdata,
	input  wire dda_lr_pkg::dda_lr_cmd_t               cmd,
	output dda_lr_pkg::dda_lr_sts_t                    sts,
	output logic [dda_lr_pkg::COORD_BITS-1:0]          pix_x,
	output logic [dda_lr_pkg::COORD_BITS-1:0]          pix_y,
	output logic [dda_lr_pkg::COLOUR_BITS-1:0]         pix_colour,
	output logic                                       pix_last
);

	localparam int C   = dda_lr_pkg::COORD_BITS;
	localparam int F   = dda_lr_pkg::FRAC_BITS;
	localparam int ACC = dda_lr_pkg::ACC_BITS;
	localparam int INC = dda_lr_pkg::INC_BITS;
	localparam int NUM = dda_lr_pkg::NUM_BITS;
	localparam int COL = dda_lr_pkg::COLOUR_BITS;

	localparam logic [ACC:0] HALF    = (ACC + 1)'(1) << (F - 1);
	localparam logic [C-1:0] MAX_CRD = {C{1'b1}};

	typedef struct packed {
		logic [C-1:0]   rem;
		logic [NUM-1:0] quo;
	} div_lane_t;

	function automatic div_lane_t div_iter(input logic [C-1:0] rem,
	                                       input logic [NUM-1:0] quo,
	                                       input logic [C-1:0] dvs);
		logic [C:0] trial;
		logic [C:0] diff;
		div_lane_t  r;
		trial = {rem, quo[NUM-1]};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			r.rem = diff[C-1:0];
			r.quo = {quo[NUM-2:0], 1'b1};
		end else begin
			r.rem = trial[C-1:0];
			r.quo = {quo[NUM-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [C-1:0] round_coord(input logic [ACC-1:0] acc);
		logic [ACC:0] r;
		logic [C:0]   v;
		logic [C-1:0] res;
		r = {acc[ACC-1], acc} + HALF;
		v = r[C+F:F];
		if (r[ACC]) begin
			res = '0;
		end else if (v > {1'b0, MAX_CRD}) begin
			res = MAX_CRD;
		end else begin
			res = v[C-1:0];
		end
		return res;
	endfunction

	function automatic logic [INC-1:0] signed_inc(input logic [NUM-1:0] quo,
	                                              input logic neg);
		logic [INC-1:0] mag;
		mag = {1'b0, quo[F:0]};
		return neg ? (INC)'(-mag) : mag;
	endfunction

	function automatic logic [ACC-1:0] add_inc(input logic [ACC-1:0] acc,
	                                           input logic [INC-1:0] inc);
		return acc + {{(ACC - INC){inc[INC-1]}}, inc};
	endfunction

	logic [C-1:0]   ax, ay, bx, by;
	logic [COL-1:0] in_colour;
	logic [C-1:0]   adx, ady, steps;
	logic [NUM-1:0] x_num, y_num;

	logic [ACC-1:0] x_acc_q, y_acc_q;
	logic [INC-1:0] x_inc_q, y_inc_q;
	logic [C-1:0]   steps_q, left_q;
	logic [COL-1:0] colour_q;
	logic           x_neg_q, y_neg_q;
	logic [C-1:0]   x_rem_q, y_rem_q;
	logic [NUM-1:0] x_quo_q, y_quo_q;
	div_lane_t      x_next, y_next;

	logic [C-1:0]   pix_x_q, pix_y_q;
	logic [COL-1:0] pix_colour_q;
	logic           pix_last_q;

	assign ax        = s_tdata[C-1:0];
	assign ay        = s_tdata[2*C-1:C];
	assign bx        = s_tdata[3*C-1:2*C];
	assign by        = s_tdata[4*C-1:3*C];
	assign in_colour = s_tdata[4*C+COL-1:4*C];

	assign adx   = (ax >= bx) ? ax - bx : bx - ax;
	assign ady   = (ay >= by) ? ay - by : by - ay;
	assign steps = (adx > ady) ? adx : ady;
	assign x_num = {adx, {F{1'b0}}} + NUM'(steps >> 1);
	assign y_num = {ady, {F{1'b0}}} + NUM'(steps >> 1);

	assign x_next = div_iter(x_rem_q, x_quo_q, steps_q);
	assign y_next = div_iter(y_rem_q, y_quo_q, steps_q);

	assign sts.steps_zero = (steps_q == '0);
	assign sts.last       = (left_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_acc_q  <= {1'b0, ax, {F{1'b0}}};
			y_acc_q  <= {1'b0, ay, {F{1'b0}}};
			x_inc_q  <= '0;
			y_inc_q  <= '0;
			steps_q  <= steps;
			left_q   <= steps;
			colour_q <= in_colour;
			x_neg_q  <= (bx < ax);
			y_neg_q  <= (by < ay);
			x_rem_q  <= '0;
			y_rem_q  <= '0;
			x_quo_q  <= x_num;
			y_quo_q  <= y_num;
		end else if (cmd.div_step) begin
			x_rem_q <= x_next.rem;
			y_rem_q <= y_next.rem;
			x_quo_q <= x_next.quo;
			y_quo_q <= y_next.quo;
			if (cmd.div_last) begin
				x_inc_q <= signed_inc(x_next.quo, x_neg_q);
				y_inc_q <= signed_inc(y_next.quo, y_neg_q);
			end
		end else if (cmd.emit) begin
			pix_x_q      <= round_coord(x_acc_q);
			pix_y_q      <= round_coord(y_acc_q);
			pix_colour_q <= colour_q;
			pix_last_q   <= sts.last;
			if (!sts.last) begin
				x_acc_q <= add_inc(x_acc_q, x_inc_q);
				y_acc_q <= add_inc(y_acc_q, y_inc_q);
				left_q  <= left_q - C'(1);
			end
		end
	end

	assign pix_x      = pix_x_q;
	assign pix_y      = pix_y_q;
	assign pix_colour = pix_colour_q;
	assign pix_last   = pix_last_q;

endmodule

`default_nettype wire

>>> rtl/dda_lr_ctrl.sv
`default_nettype none

module dda_lr_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_func,
	output logic                         s_tready,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	input  wire dda_lr_pkg::dda_lr_sts_t sts,
	output dda_lr_pkg::dda_lr_cmd_t      cmd
);

	typedef enum logic [1:0] {
		IDLE_S,
		DIV_S,
		DRAW_S
	} state_t;

	localparam logic [dda_lr_pkg::CNT_BITS-1:0] DIV_LAST =
		dda_lr_pkg::CNT_BITS'(dda_lr_pkg::NUM_BITS - 1);

	state_t                            state_q;
	logic [dda_lr_pkg::CNT_BITS-1:0]   cnt_q;
	logic                              out_valid_q;
	logic                              accept;

	assign s_tready = (state_q != DIV_S) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (s_func == dda_lr_pkg::FUNC_START);
		cmd.emit     = accept && (s_func == dda_lr_pkg::FUNC_STEP) && (state_q == DRAW_S);
		cmd.div_step = (state_q == DIV_S) && !sts.steps_zero;
		cmd.div_last = cmd.div_step && (cnt_q == DIV_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE_S;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE_S, DRAW_S: begin
					if (cmd.load) begin
						state_q <= DIV_S;
						cnt_q   <= '0;
					end else if (cmd.emit && sts.last) begin
						state_q <= IDLE_S;
					end
				end
				DIV_S: begin
					if (sts.steps_zero || cmd.div_last) begin
						state_q <= DRAW_S;
					end else begin
						cnt_q <= cnt_q + dda_lr_pkg::CNT_BITS'(1);
					end
				end
				default: begin
					state_q <= IDLE_S;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/dda_line_rasterizer_core.sv
// DDA line rasterizer.
// The input stream carries one command per transaction. tuser selects the
// command: a start transaction latches both endpoints and the pen colour, and
// a step transaction asks for the next pixel of the current line.
// A start produces no output. It computes the step count as the larger of the
// absolute x and y distances and then divides once per axis to get signed
// fixed-point slopes. Each axis has its own divider lane, retiring one quotient
// bit per cycle, so after a start the input is held off until the quotients are
// complete; a line of a single point skips the division.
// While a line is drawn, each step transaction yields one pixel on the output
// stream, in the cycle after acceptance, and a new step may be accepted in every
// cycle while the receiver takes each pixel. The pixel with tlast set is the end
// point, after which the block is idle and ignores steps until the next start.
// A start during a line abandons it. The output holds one registered pixel;
// when the receiver stalls, the input is held off until that pixel is taken.
// Reset clears the controller and the output valid, leaving the block idle.

`default_nettype none

module dda_line_rasterizer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// start_x, start_y, end_x, end_y, pen_colour, zero fill.
	input  wire logic [dda_lr_pkg::S_TDATA_BITS-1:0] s_tdata,
	// func.
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// pixel_x, pixel_y, pixel_colour.
	output logic [dda_lr_pkg::M_TDATA_BITS-1:0]      m_tdata,
	output logic                                     m_tlast
);

	dda_lr_pkg::dda_lr_cmd_t                 cmd;
	dda_lr_pkg::dda_lr_sts_t                 sts;
	logic [dda_lr_pkg::COORD_BITS-1:0]       pix_x, pix_y;
	logic [dda_lr_pkg::COLOUR_BITS-1:0]      pix_colour;

	dda_lr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dda_lr_datapath u_datapath (
		.clk        (clk),
		.s_tdata    (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.pix_colour (pix_colour),
		.pix_last   (m_tlast)
	);

	assign m_tdata = dda_lr_pkg::M_TDATA_BITS'({pix_colour, pix_y, pix_x});

	a_start_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == dda_lr_pkg::FUNC_START)) |=> !s_tready)
		else $error("input accepted right after a start transaction");

	a_div_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_tready)
		else $error("input ready while the divider runs");

	a_load_emit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.emit))
		else $error("load and emit in the same cycle");

	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == dda_lr_pkg::FUNC_STEP)))
		else $error("output transaction without an accepted step");

endmodule

`default_nettype wire

>>> tb/sv/dda_line_checker.sv
`default_nettype none

module dda_line_checker
	import dda_lr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_tready,
	// start_x, start_y, end_x, end_y, pen_colour, zero fill.
	input  wire logic [S_TDATA_BITS-1:0] s_tdata,
	// func.
	input  wire logic                    s_tuser,
	input  wire logic                    m_tvalid,
	input  wire logic                    m_tready,
	// pixel_x, pixel_y, pixel_colour.
	input  wire logic [M_TDATA_BITS-1:0] m_tdata,
	input  wire logic                    m_tlast,
	output int                           mismatches,
	output int                           pixels_owed
);

	typedef struct packed {
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [COLOUR_BITS-1:0] colour;
		logic                   last;
	} pixel_t;

	pixel_t                     expected_pixels[$];
	logic signed [ACC_BITS-1:0] x_acc;
	logic signed [ACC_BITS-1:0] y_acc;
	logic signed [INC_BITS-1:0] x_inc;
	logic signed [INC_BITS-1:0] y_inc;
	logic [COORD_BITS:0]        steps_left;
	logic [COLOUR_BITS-1:0]     line_colour;
	logic                       drawing;

	// Slope per step, rounded to nearest with ties away from zero.
	function automatic logic signed [INC_BITS-1:0] slope(input longint from, input longint to,
		input longint steps);
		longint mag;
		if (steps == 0)
			return '0;
		mag = (((from > to ? from - to : to - from) << FRAC_BITS) + (steps >> 1)) / steps;
		return (to >= from) ? INC_BITS'(mag) : INC_BITS'(-mag);
	endfunction

	// Round half up and clamp to the screen.
	function automatic logic [COORD_BITS-1:0] round_pos(input logic signed [ACC_BITS-1:0] acc);
		longint r;
		r = longint'(acc) + (longint'(1) << (FRAC_BITS - 1));
		if (r < 0)
			return '0;
		r = r >>> FRAC_BITS;
		if (r > (longint'(1) << COORD_BITS) - 1)
			return '1;
		return COORD_BITS'(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t got;
		pixel_t want;
		longint ax;
		longint ay;
		longint bx;
		longint by;
		longint adx;
		longint ady;
		longint steps;
		if (!arst_n) begin
			x_acc = '0;
			y_acc = '0;
			x_inc = '0;
			y_inc = '0;
			steps_left = '0;
			line_colour = '0;
			drawing = 1'b0;
			mismatches = 0;
			expected_pixels.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[0 +: COORD_BITS];
				got.y = m_tdata[COORD_BITS +: COORD_BITS];
				got.colour = m_tdata[2*COORD_BITS +: COLOUR_BITS];
				got.last = m_tlast;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel at %0t: x=%0d y=%0d colour=%0d last=%0b",
							$time, got.x, got.y, got.colour, got.last);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("pixel mismatch at %0t: expected x=%0d y=%0d colour=%0d last=%0b",
								$time, want.x, want.y, want.colour, want.last);
							$display("  got x=%0d y=%0d colour=%0d last=%0b",
								got.x, got.y, got.colour, got.last);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_START) begin
					ax = s_tdata[0 +: COORD_BITS];
					ay = s_tdata[COORD_BITS +: COORD_BITS];
					bx = s_tdata[2*COORD_BITS +: COORD_BITS];
					by = s_tdata[3*COORD_BITS +: COORD_BITS];
					adx = (ax > bx) ? ax - bx : bx - ax;
					ady = (ay > by) ? ay - by : by - ay;
					steps = (adx > ady) ? adx : ady;
					x_inc = slope(ax, bx, steps);
					y_inc = slope(ay, by, steps);
					x_acc = ACC_BITS'(ax << FRAC_BITS);
					y_acc = ACC_BITS'(ay << FRAC_BITS);
					steps_left = steps[COORD_BITS:0];
					line_colour = s_tdata[4*COORD_BITS +: COLOUR_BITS];
					drawing = 1'b1;
				end else if (drawing) begin
					want.x = round_pos(x_acc);
					want.y = round_pos(y_acc);
					want.colour = line_colour;
					want.last = (steps_left == 0);
					expected_pixels.push_back(want);
					if (steps_left == 0) begin
						drawing = 1'b0;
					end else begin
						x_acc = x_acc + x_inc;
						y_acc = y_acc + y_inc;
						steps_left = steps_left - (COORD_BITS + 1)'(1);
					end
				end
			end
		end
		pixels_owed = expected_pixels.size();
	end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
	import dda_lr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 256;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic [S_TDATA_BITS-1:0] s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tready = 1'b0;
	wire                     s_tready;
	wire                     m_tvalid;
	wire [M_TDATA_BITS-1:0]  m_tdata;
	wire                     m_tlast;

	int   mismatches;
	int   pixels_owed;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   cycles = 0;
	bit   hold_req = 1'b0;
	logic hold_off = 1'b0;

	dda_line_rasterizer_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	dda_line_checker pixel_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pixels_owed(pixels_owed)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
	end

	// The receiver goes quiet for a long stretch so that the block backs up.
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic send_item(input logic func, input logic [COORD_BITS-1:0] ax,
		input logic [COORD_BITS-1:0] ay, input logic [COORD_BITS-1:0] bx,
		input logic [COORD_BITS-1:0] by, input logic [COLOUR_BITS-1:0] colour);
		logic [S_TDATA_BITS-1:0] data;
		data = '0;
		data[4*COORD_BITS+COLOUR_BITS-1:0] = {colour, by, bx, ay, ax};
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic draw_line(input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
		input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
		input logic [COLOUR_BITS-1:0] colour, input int pixels);
		send_item(FUNC_START, ax, ay, bx, by, colour);
		repeat (pixels)
			send_item(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Mostly short, complete lines; some are cut short by the next start and some
	// are followed by steps that arrive after the end point.
	task automatic random_line(input bit long_line, output int counted);
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [COORD_BITS-1:0] bx;
		logic [COORD_BITS-1:0] by;
		int dx;
		int dy;
		int steps;
		int pixels;
		int r;
		ax = $urandom;
		ay = $urandom;
		if (long_line) begin
			bx = $urandom;
			by = $urandom;
		end else begin
			dx = $urandom_range(0, 24);
			dy = $urandom_range(0, 24);
			bx = ((int'(ax) + dx <= 1023) && ($urandom_range(0, 1) || int'(ax) < dx)) ?
				ax + dx : ax - dx;
			by = ((int'(ay) + dy <= 1023) && ($urandom_range(0, 1) || int'(ay) < dy)) ?
				ay + dy : ay - dy;
		end
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		steps = (dx > dy) ? dx : dy;
		r = $urandom_range(0, 99);
		if (long_line)
			pixels = $urandom_range(0, 30);
		else if (r < 75)
			pixels = steps + 1;
		else if (r < 90)
			pixels = $urandom_range(0, steps);
		else
			pixels = steps + 1 + $urandom_range(1, 3);
		draw_line(ax, ay, bx, by, $urandom, pixels);
		counted = 1 + ((pixels < steps + 1) ? pixels : steps + 1);
	endtask

	initial begin : stimulus
		int idle_table[4];
		int stall_table[4];
		int total;
		int counted;
		int r;
		idle_table = '{0, 50, 0, 17};
		stall_table = '{0, 0, 50, 17};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_STEP, '1, '1, '1, '1, '1);
		draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 4'd15, 2);
		draw_line(10'd0, 10'd0, 10'd3, 10'd1, 4'd0, 4);
		draw_line(10'd1023, 10'd0, 10'd1020, 10'd5, 4'd9, 6);
		draw_line(10'd0, 10'd1023, 10'd1023, 10'd0, 4'd10, 2);
		draw_line(10'd5, 10'd5, 10'd5, 10'd0, 4'd6, 6);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_table[phase];
			stall_pct = stall_table[phase];
			total = 0;
			if (phase == 2) begin
				hold_req = 1'b1;
				draw_line(10'd10, 10'd20, 10'd210, 10'd100, 4'd3, 150);
				total = 151;
			end
			while (total < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				end else begin
					random_line(r < 12, counted);
					total += counted;
				end
			end
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;

		while (pixels_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
